// ===== design/murmur3_32_stream_hash_unit_assert.svh =====
// Assertion macros used by the checker file of the hash unit.
`ifndef MURMUR3_32_STREAM_HASH_UNIT_ASSERT_SVH
`define MURMUR3_32_STREAM_HASH_UNIT_ASSERT_SVH

// Next-cycle implication, masked while reset is asserted
`define M3H_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("m3h assertion failed");

// Next-cycle implication that also holds through reset
`define M3H_ASSERT_NXT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("m3h assertion failed");

`endif

// ===== design/m3h_pkg.sv =====
`default_nettype none

package m3h_pkg;

  localparam logic [31:0] SEED_RESET = 32'h1234_5678;
  localparam logic [31:0] MM_C1      = 32'hcc9e_2d51;
  localparam logic [31:0] MM_C2      = 32'h1b87_3593;
  localparam logic [31:0] MM_ADD     = 32'he654_6b64;
  localparam logic [31:0] MM_F1      = 32'h85eb_ca6b;
  localparam logic [31:0] MM_F2      = 32'hc2b2_ae35;
  localparam logic [2:0]  FULL_COUNT = 3'd4;

  // Operand selection of the shared multiplier
  typedef enum logic [1:0] {
    MUL_C1,
    MUL_C2,
    MUL_F1,
    MUL_F2
  } mul_op_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    capture;
    logic    mul_en;
    mul_op_t mul_op;
    logic    mix;
    logic    finish;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic ending;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/m3h_stream_if.sv =====
`default_nettype none

// Input channel: one key word per beat
interface m3h_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_word;

  modport source (output valid, output data_word, output byte_count, output last_word,
                  input ready);
  modport sink (input valid, input data_word, input byte_count, input last_word,
                output ready);
endinterface

// Result channel: one hash per beat
interface m3h_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash;

  modport source (output valid, output hash, input ready);
  modport sink (input valid, input hash, output ready);
endinterface

`default_nettype wire

// ===== design/m3h_ctrl.sv =====
`default_nettype none

module m3h_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire m3h_pkg::sts_t sts,
  output m3h_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MIX,
    S_FIN1,
    S_FIN2,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_MIX;
      S_MIX:  state_nxt = sts.ending ? S_FIN1 : S_IDLE;
      S_FIN1: state_nxt = S_FIN2;
      S_FIN2: state_nxt = S_OUT;
      S_OUT:  state_nxt = sts.out_busy ? S_OUT : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Command decode
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = m3h_pkg::MUL_C1;
      end
      S_MUL2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = m3h_pkg::MUL_C2;
      end
      S_MIX:  cmd.mix = 1'b1;
      S_FIN1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = m3h_pkg::MUL_F1;
      end
      S_FIN2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = m3h_pkg::MUL_F2;
      end
      S_OUT:  cmd.finish = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/m3h_dpath.sv =====
`default_nettype none

module m3h_dpath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire m3h_pkg::cmd_t cmd,
  output m3h_pkg::sts_t      sts,
  input  wire logic [31:0]   in_data_word,
  input  wire logic [2:0]    in_byte_count,
  input  wire logic          in_last_word,
  input  wire logic          cfg_we,
  input  wire logic [31:0]   cfg_data,
  input  wire logic          out_ready,
  output logic               out_valid,
  output logic [31:0]        out_hash
);

  logic [31:0] seed_r;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] len_r, len_nxt;
  logic        key_open_r;
  logic [31:0] word_r;
  logic [2:0]  cnt_r;
  logic        last_r;
  logic [31:0] acc_r;
  logic        out_valid_r;
  logic [31:0] out_hash_r;

  logic [2:0]  cnt_clamp;
  logic [31:0] word_mask;
  logic [31:0] mul_a, mul_b, mul_p;
  logic [31:0] h_x, h_rot, h_body;
  logic        full_word;

  // Clamp the count and drop bytes beyond it
  always_comb begin
    cnt_clamp = (in_byte_count > m3h_pkg::FULL_COUNT) ? m3h_pkg::FULL_COUNT : in_byte_count;
    case (cnt_clamp)
      3'd0:    word_mask = 32'h0000_0000;
      3'd1:    word_mask = 32'h0000_00ff;
      3'd2:    word_mask = 32'h0000_ffff;
      3'd3:    word_mask = 32'h00ff_ffff;
      default: word_mask = 32'hffff_ffff;
    endcase
  end

  // Shared multiplier, low 32 bits of the product
  always_comb begin
    case (cmd.mul_op)
      m3h_pkg::MUL_C1: begin
        mul_a = word_r;
        mul_b = m3h_pkg::MM_C1;
      end
      m3h_pkg::MUL_C2: begin
        mul_a = {acc_r[16:0], acc_r[31:17]};
        mul_b = m3h_pkg::MM_C2;
      end
      m3h_pkg::MUL_F1: begin
        mul_a = acc_r ^ {16'h0, acc_r[31:16]};
        mul_b = m3h_pkg::MM_F1;
      end
      m3h_pkg::MUL_F2: begin
        mul_a = acc_r ^ {13'h0, acc_r[31:13]};
        mul_b = m3h_pkg::MM_F2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Block mix; a zero premix (empty tail) leaves the hash as is
  always_comb begin
    full_word = (cnt_r == m3h_pkg::FULL_COUNT);
    h_x       = hash_r ^ acc_r;
    h_rot     = {h_x[18:0], h_x[31:19]};
    h_body    = {h_rot[29:0], 2'b00} + h_rot + m3h_pkg::MM_ADD;
    len_nxt   = len_r + {29'h0, cnt_r};
    hash_nxt  = full_word ? h_body : h_x;
  end

  assign sts.ending   = !full_word || last_r;
  assign sts.out_busy = out_valid_r && !out_ready;

  // Captured beat and working register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      word_r <= in_data_word & word_mask;
      cnt_r  <= cnt_clamp;
      last_r <= in_last_word;
    end
    if (cmd.mul_en) begin
      acc_r <= mul_p;
    end else if (cmd.mix) begin
      acc_r <= hash_nxt ^ len_nxt;
    end
    if (cmd.finish) begin
      out_hash_r <= acc_r ^ {16'h0, acc_r[31:16]};
    end
  end

  // Key state, seed and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= m3h_pkg::SEED_RESET;
      hash_r      <= m3h_pkg::SEED_RESET;
      len_r       <= '0;
      key_open_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_data;
        if (!key_open_r) begin
          hash_r <= cfg_data;
        end
      end
      if (cmd.mix) begin
        len_r <= len_nxt;
        if (!sts.ending) begin
          hash_r     <= hash_nxt;
          key_open_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        hash_r      <= seed_r;
        len_r       <= '0;
        key_open_r  <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_hash  = out_hash_r;

endmodule

`default_nettype wire

// ===== design/murmur3_32_stream_hash_unit.sv =====
// A key's last beat passes the two premix products, the mix and the two
// finalizer products of one shared 32x32 multiplier before its hash is
// registered; no new word is taken until the last is through. An ending
// word waits while the previous hash is unread.
// Reset: synchronous active-low; seed and running hash return to 0x12345678,
// length clears, the output holds no hash.
`default_nettype none

module murmur3_32_stream_hash_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  m3h_in_if.sink           in_bus,
  m3h_out_if.source        out_bus,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data
);

  m3h_pkg::cmd_t cmd;
  m3h_pkg::sts_t sts;
  logic          in_ready;

  assign in_bus.ready = in_ready;

  m3h_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  m3h_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_data_word  (in_bus.data_word),
    .in_byte_count (in_bus.byte_count),
    .in_last_word  (in_bus.last_word),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .out_ready     (out_bus.ready),
    .out_valid     (out_bus.valid),
    .out_hash      (out_bus.hash)
  );

endmodule

`default_nettype wire

// ===== design/m3h_checker.sv =====
`default_nettype none
`include "murmur3_32_stream_hash_unit_assert.svh"

module m3h_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_hash
);

  // A waiting hash holds until taken
  `M3H_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_hash))

  // Every beat keeps the input busy through its premix products before the next
  `M3H_ASSERT_NXT(a_busy_after_beat, clk, rst_n, in_valid && in_ready, !in_ready)
  `M3H_ASSERT_NXT(a_busy_two, clk, rst_n, $past(in_valid && in_ready), !in_ready)

  // Reset empties the output
  `M3H_ASSERT_NXT_RST(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind murmur3_32_stream_hash_unit m3h_checker u_m3h_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_hash  (out_bus.hash)
);

`default_nettype wire
